### design/ifp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants for the IPv4 fragment planner.
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int MtuW       = 14;
    localparam int AluW       = 18;
    localparam int HdrW       = 5;

    localparam logic [MtuW-1:0] MTU_RESET = 14'd1500;
    localparam logic [MtuW-1:0] MTU_MIN   = 14'd1100;
    localparam logic [MtuW-1:0] MTU_MAX   = 14'd9216;
    localparam logic [HdrW-1:0] HDR_BASE  = 5'd20;
    localparam logic [HdrW-1:0] HDR_RA    = 5'd24;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_L4_FIT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_TOT,
        S_CAP,
        S_FIT,
        S_L4,
        S_ID,
        S_FRAG
    } state_t;

    typedef struct packed {
        logic [AluW-1:0] a;
        logic [AluW-1:0] b;
        logic            sub;
    } alu_req_t;

    typedef struct packed {
        logic [AluW-1:0] res;
        logic            borrow;
    } alu_rsp_t;

    typedef struct packed {
        logic [15:0] l4_header_len;
        logic [15:0] payload_len;
        logic        has_fixed_id;
        logic [15:0] fixed_id;
        logic        router_alert;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] data_len;
        logic [12:0] offset_units;
        logic        more_fragments;
        logic [13:0] total_length;
        logic [15:0] identification;
        logic        last;
    } frag_t;

endpackage

### design/ipv4_fragment_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_fragment_planner
// Splits one IPv4 datagram request into per-fragment results.
//
//  Group  Dir  Contents
//  s_     in   request: tdata only
//  m_     out  fragment result: tdata, tuser (status), tlast
//  cfg_   in   MTU register write
//
// After a request transfer, SUM, TOT, CAP, FIT, L4 and ID run, then one fragment
// result per cycle on the shared unit while m_tready is high; up to 62 fragments.
// Oversize requests end in TOT, unfragmented ones in FIT, L4 failures in L4.
// Reset (aresetn low, synchronous): MTU 1500, automatic ID 1, output empty.
// m_tready low holds the fragment loop; s_tready is high only when idle.
// ----------------------------------------------------------------------------
module ipv4_fragment_planner #(
    parameter logic [ifp_pkg::MtuW-1:0] MTU_RESET_VAL = ifp_pkg::MTU_RESET
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] l4_header_len, [31:16] payload_len, [32] has_fixed_id,
    // [48:33] fixed_id, [49] router_alert, [55:50] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [13:0] data_len, [26:14] offset_units, [27] more_fragments,
    // [41:28] total_length, [57:42] identification, [63:58] zero
    output logic [63:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data
);
    import ifp_pkg::*;

    logic [MtuW-1:0] mtu_reg;
    logic [MtuW-1:0] mtu_sat;
    req_t            req;
    frag_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg <= MTU_RESET_VAL;
        end else if (cfg_valid) begin
            mtu_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        if (mtu_reg < MTU_MIN) begin
            mtu_sat = MTU_MIN;
        end else if (mtu_reg > MTU_MAX) begin
            mtu_sat = MTU_MAX;
        end else begin
            mtu_sat = mtu_reg;
        end
    end

    assign req.l4_header_len = s_tdata[15:0];
    assign req.payload_len   = s_tdata[31:16];
    assign req.has_fixed_id  = s_tdata[32];
    assign req.fixed_id      = s_tdata[48:33];
    assign req.router_alert  = s_tdata[49];

    ifp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mtu_sat  (mtu_sat),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req      (req),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    assign m_tdata = {6'd0, res.identification, res.total_length, res.more_fragments,
                      res.offset_units, res.data_len};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

### design/ifp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_alu
// Shared add/subtract unit; reports borrow on subtract.
// ----------------------------------------------------------------------------
module ifp_alu (
    input  ifp_pkg::alu_req_t req,
    output ifp_pkg::alu_rsp_t rsp
);
    import ifp_pkg::*;

    logic [AluW:0] sum;

    always_comb begin
        sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{AluW{1'b0}}, req.sub};
        rsp.res    = sum[AluW-1:0];
        rsp.borrow = req.sub & ~sum[AluW];
    end

endmodule

### design/ifp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_seq
// Request sequencer: checks, fragment loop on the shared unit, result register.
// ----------------------------------------------------------------------------
module ifp_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ifp_pkg::MtuW-1:0]   mtu_sat,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ifp_pkg::req_t              req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output ifp_pkg::frag_t             res
);
    import ifp_pkg::*;

    state_t          state_reg, state_next;
    logic [15:0]     l4_reg, l4_next;
    logic [15:0]     pl_reg, pl_next;
    logic            hasid_reg, hasid_next;
    logic [15:0]     fid_reg, fid_next;
    logic [HdrW-1:0] hdr_reg, hdr_next;
    logic [MtuW-1:0] mtu_reg, mtu_next;
    logic [16:0]     data_reg, data_next;
    logic [MtuW-1:0] cap_reg, cap_next;
    logic [16:0]     rem_reg, rem_next;
    logic [12:0]     off_reg, off_next;
    logic [15:0]     id_reg, id_next;
    logic [15:0]     nid_reg, nid_next;
    logic            ov_reg, ov_next;
    frag_t           out_reg, out_next;

    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;
    logic            load_ok;
    logic [MtuW-1:0] step;
    logic            more;

    ifp_alu u_alu (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    assign load_ok   = ~ov_reg | res_ready;
    assign step      = {cap_reg[MtuW-1:3], 3'b000};
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = ov_reg;
    assign res       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            nid_reg   <= 16'd1;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            nid_reg   <= nid_next;
        end
        l4_reg    <= l4_next;
        pl_reg    <= pl_next;
        hasid_reg <= hasid_next;
        fid_reg   <= fid_next;
        hdr_reg   <= hdr_next;
        mtu_reg   <= mtu_next;
        data_reg  <= data_next;
        cap_reg   <= cap_next;
        rem_reg   <= rem_next;
        off_reg   <= off_next;
        id_reg    <= id_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        l4_next    = l4_reg;
        pl_next    = pl_reg;
        hasid_next = hasid_reg;
        fid_next   = fid_reg;
        hdr_next   = hdr_reg;
        mtu_next   = mtu_reg;
        data_next  = data_reg;
        cap_next   = cap_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        id_next    = id_reg;
        nid_next   = nid_reg;
        ov_next    = ov_reg & ~res_ready;
        out_next   = out_reg;
        alu_req    = '0;
        more       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    l4_next    = req.l4_header_len;
                    pl_next    = req.payload_len;
                    hasid_next = req.has_fixed_id;
                    fid_next   = req.fixed_id;
                    hdr_next   = req.router_alert ? HDR_RA : HDR_BASE;
                    mtu_next   = mtu_sat;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                alu_req.a  = {2'b00, l4_reg};
                alu_req.b  = {2'b00, pl_reg};
                data_next  = alu_rsp.res[16:0];
                state_next = S_TOT;
            end
            S_TOT: begin
                alu_req.a = {1'b0, data_reg};
                alu_req.b = {{(AluW-HdrW){1'b0}}, hdr_reg};
                if (|alu_rsp.res[AluW-1:16]) begin
                    if (load_ok) begin
                        ov_next         = 1'b1;
                        out_next        = '0;
                        out_next.status = ST_TOO_BIG;
                        out_next.last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                alu_req.a  = {{(AluW-MtuW){1'b0}}, mtu_reg};
                alu_req.b  = {{(AluW-HdrW){1'b0}}, hdr_reg};
                alu_req.sub = 1'b1;
                cap_next   = alu_rsp.res[MtuW-1:0];
                state_next = S_FIT;
            end
            S_FIT: begin
                alu_req.a   = {{(AluW-MtuW){1'b0}}, cap_reg};
                alu_req.b   = {1'b0, data_reg};
                alu_req.sub = 1'b1;
                if (alu_rsp.borrow) begin
                    state_next = S_L4;
                end else if (load_ok) begin
                    ov_next                 = 1'b1;
                    out_next.status         = ST_OK;
                    out_next.data_len       = data_reg[13:0];
                    out_next.offset_units   = '0;
                    out_next.more_fragments = 1'b0;
                    out_next.total_length   = data_reg[13:0] + {9'd0, hdr_reg};
                    out_next.identification = fid_reg;
                    out_next.last           = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            S_L4: begin
                alu_req.a   = {{(AluW-MtuW){1'b0}}, step};
                alu_req.b   = {2'b00, l4_reg};
                alu_req.sub = 1'b1;
                if (alu_rsp.borrow) begin
                    if (load_ok) begin
                        ov_next         = 1'b1;
                        out_next        = '0;
                        out_next.status = ST_L4_FIT;
                        out_next.last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    rem_next   = data_reg;
                    off_next   = '0;
                    state_next = S_ID;
                end
            end
            S_ID: begin
                alu_req.a = {2'b00, nid_reg};
                alu_req.b = {{(AluW-1){1'b0}}, 1'b1};
                if (hasid_reg) begin
                    id_next = fid_reg;
                end else begin
                    id_next  = nid_reg;
                    nid_next = alu_rsp.res[15:0];
                end
                state_next = S_FRAG;
            end
            S_FRAG: begin
                alu_req.a   = {1'b0, rem_reg};
                alu_req.b   = {{(AluW-MtuW){1'b0}}, step};
                alu_req.sub = 1'b1;
                more        = ~alu_rsp.borrow & (|alu_rsp.res);
                if (load_ok) begin
                    ov_next                 = 1'b1;
                    out_next.status         = ST_OK;
                    out_next.data_len       = more ? step : rem_reg[13:0];
                    out_next.offset_units   = off_reg;
                    out_next.more_fragments = more;
                    out_next.total_length   = (more ? step : rem_reg[13:0]) + {9'd0, hdr_reg};
                    out_next.identification = id_reg;
                    out_next.last           = ~more;
                    rem_next                = alu_rsp.res[16:0];
                    off_next                = off_reg + {2'b00, step[MtuW-1:3]};
                    if (!more) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
